FILE: rtl/modexp_pkg.sv
// Package for the modular exponentiation core: widths, state encodings, control structs.
`timescale 1ns / 1ps
`default_nettype none
package modexp_pkg;
	localparam int OPERAND_WIDTH = 32;
	localparam int CNT_W = $clog2(OPERAND_WIDTH + 1);
	localparam logic [OPERAND_WIDTH-1:0] MODULUS_RESET = OPERAND_WIDTH'(1000);

	typedef logic [OPERAND_WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MULT,
		ST_SQUARE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_IDLE,
		MUL_RUN,
		MUL_DONE
	} mul_state_t;

	typedef struct packed {
		logic start;
	} mul_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;
endpackage
`default_nettype wire

FILE: rtl/modular_exponentiation_core.sv
// Top level of the modular exponentiation core: sequencer, operand registers and handshakes.
// Usage:
//  - The user must write modulus through modulus_we / modulus_wdata only while the core is
//    idle (the core does not check). It resets to 1000; modulus 0 or 1 gives a result of 0.
//  - Input channel in_valid / in_stall carries base_value and exponent; a transfer
//    happens on an edge with in_valid high and in_stall low. in_stall is high from the
//    transfer until the result has been taken, so one item is in flight at a time.
//  - Output channel out_valid / out_stall carries power_result; the result holds in an
//    output register while out_stall is high.
// Sequence: the base is first reduced by a bit-serial remainder unit. Then, for every
//  exponent bit up to the highest one, an optional multiply and a square each run
//  through one shared bit-serial multiplier. Exponent zero skips the multiply and
//  square steps; modulus <= 1 skips the reduction as well.
// Reset (arst_n low, asynchronous): the sequencer returns to idle, no result is valid and
//  the modulus register returns to 1000.
`timescale 1ns / 1ps
`default_nettype none
module modular_exponentiation_core (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      modulus_we,
	input  wire [31:0]               modulus_wdata,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire [31:0]               base_value,
	input  wire [31:0]               exponent,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic [31:0]              power_result
);
	import modexp_pkg::*;

	state_t    state_q, state_d;
	word_t     modulus_q;
	word_t     base_q, exp_q, res_q, out_q;
	logic      out_valid_q;
	mul_ctrl_t mul_ctrl, red_ctrl;
	mul_stat_t mul_stat, red_stat;
	word_t     mul_a, mul_b, mul_p, red_r;
	logic      accept;
	logic      trivial;

	// modulus register, masked to the datapath width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RESET;
		end else if (modulus_we) begin
			modulus_q <= word_t'(modulus_wdata);
		end
	end

	assign accept  = in_valid && !in_stall;
	assign trivial = (modulus_q <= word_t'(1));

	modexp_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (red_ctrl),
		.x         (base_q),
		.m         (modulus_q),
		.stat      (red_stat),
		.remainder (red_r)
	);

	// one shared multiplier for both the multiply and the square steps
	assign mul_a = base_q;
	assign mul_b = (state_q == ST_MULT) ? res_q : base_q;

	modexp_mulmod u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (mul_ctrl),
		.a       (mul_a),
		.b       (mul_b),
		.m       (modulus_q),
		.stat    (mul_stat),
		.product (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		mul_ctrl.start = 1'b0;
		red_ctrl.start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				// start pulse while the unit is idle, then wait for done
				red_ctrl.start = !red_stat.busy && !trivial;
				if (trivial || red_stat.done) begin
					state_d = (trivial || exp_q == '0) ? ST_DONE
						: (exp_q[0] ? ST_MULT : ST_SQUARE);
				end
			end
			ST_MULT: begin
				mul_ctrl.start = !mul_stat.busy;
				if (mul_stat.done) begin
					state_d = ST_SQUARE;
				end
			end
			ST_SQUARE: begin
				mul_ctrl.start = !mul_stat.busy;
				if (mul_stat.done) begin
					// exp_q is shifted on this edge; look at the next bit now
					if (exp_q[OPERAND_WIDTH-1:1] == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = exp_q[1] ? ST_MULT : ST_SQUARE;
					end
				end
			end
			ST_DONE: begin
				if (!out_valid_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operand registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					base_q <= word_t'(base_value);
					exp_q  <= word_t'(exponent);
					res_q  <= word_t'(1);
				end
			end
			ST_REDUCE: begin
				if (red_stat.done) begin
					base_q <= red_r;
				end
			end
			ST_MULT: begin
				if (mul_stat.done) begin
					res_q <= mul_p;
				end
			end
			ST_SQUARE: begin
				if (mul_stat.done) begin
					base_q <= mul_p;
					exp_q  <= {1'b0, exp_q[OPERAND_WIDTH-1:1]};
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && !out_valid_q) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !out_valid_q) begin
			out_q <= trivial ? '0 : res_q;
		end
	end

	assign in_stall     = (state_q != ST_IDLE) || out_valid_q;
	assign out_valid    = out_valid_q;
	assign power_result = 32'(out_q);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall) else $error("input taken while busy");
	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT || state_q == ST_SQUARE) && !trivial |-> res_q < modulus_q)
		else $error("running result not reduced");
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && red_stat.busy)) else $error("both serial units busy");
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE) else $error("stray result");
endmodule
`default_nettype wire

FILE: rtl/modexp_mulmod.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, double-and-add mod m.
`timescale 1ns / 1ps
`default_nettype none
module modexp_mulmod (
	input  wire                   clk,
	input  wire                   arst_n,
	input  modexp_pkg::mul_ctrl_t ctrl,
	input  modexp_pkg::word_t     a,
	input  modexp_pkg::word_t     b,
	input  modexp_pkg::word_t     m,
	output modexp_pkg::mul_stat_t stat,
	output modexp_pkg::word_t     product
);
	import modexp_pkg::*;

	mul_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	word_t            acc_q, bsh_q, a_q, m_q;
	word_t            dbl, sum;

	// add_mod: (x + y) mod m for x, y < m, without overflow
	function automatic word_t add_mod(input word_t x, input word_t y, input word_t md);
		word_t diff;
		diff = md - y;
		return (x >= diff) ? (x - diff) : (x + y);
	endfunction

	always_comb begin
		dbl = add_mod(acc_q, acc_q, m_q);
		sum = bsh_q[OPERAND_WIDTH-1] ? add_mod(dbl, a_q, m_q) : dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MUL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MUL_IDLE: if (ctrl.start) state_d = MUL_RUN;
			MUL_RUN:  if (cnt_q == CNT_W'(1)) state_d = MUL_DONE;
			MUL_DONE: state_d = MUL_IDLE;
			default:  state_d = MUL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == MUL_IDLE && ctrl.start) begin
			cnt_q <= CNT_W'(OPERAND_WIDTH);
		end else if (state_q == MUL_RUN) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MUL_IDLE && ctrl.start) begin
			acc_q <= '0;
			bsh_q <= b;
			a_q   <= a;
			m_q   <= m;
		end else if (state_q == MUL_RUN) begin
			acc_q <= sum;
			bsh_q <= {bsh_q[OPERAND_WIDTH-2:0], 1'b0};
		end
	end

	assign stat.busy = (state_q != MUL_IDLE);
	assign stat.done = (state_q == MUL_DONE);
	assign product   = acc_q;

	a_cnt_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MUL_RUN |-> cnt_q != '0) else $error("mulmod counter ran out");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MUL_DONE |=> state_q == MUL_IDLE) else $error("mulmod done held");
	a_result_lt_m: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MUL_DONE |-> acc_q < m_q) else $error("mulmod result not reduced");
endmodule
`default_nettype wire

FILE: rtl/modexp_reduce.sv
// Bit-serial remainder unit: restoring reduction x mod m, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module modexp_reduce (
	input  wire                   clk,
	input  wire                   arst_n,
	input  modexp_pkg::mul_ctrl_t ctrl,
	input  modexp_pkg::word_t     x,
	input  modexp_pkg::word_t     m,
	output modexp_pkg::mul_stat_t stat,
	output modexp_pkg::word_t     remainder
);
	import modexp_pkg::*;

	mul_state_t             state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	word_t                  rem_q, xsh_q, m_q;
	logic [OPERAND_WIDTH:0] shifted;
	word_t                  rem_d;

	always_comb begin
		shifted = {rem_q, xsh_q[OPERAND_WIDTH-1]};
		if (shifted >= {1'b0, m_q}) begin
			rem_d = OPERAND_WIDTH'(shifted - {1'b0, m_q});
		end else begin
			rem_d = shifted[OPERAND_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MUL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			MUL_IDLE: if (ctrl.start) state_d = MUL_RUN;
			MUL_RUN:  if (cnt_q == CNT_W'(1)) state_d = MUL_DONE;
			MUL_DONE: state_d = MUL_IDLE;
			default:  state_d = MUL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == MUL_IDLE && ctrl.start) begin
			cnt_q <= CNT_W'(OPERAND_WIDTH);
		end else if (state_q == MUL_RUN) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MUL_IDLE && ctrl.start) begin
			rem_q <= '0;
			xsh_q <= x;
			m_q   <= m;
		end else if (state_q == MUL_RUN) begin
			rem_q <= rem_d;
			xsh_q <= {xsh_q[OPERAND_WIDTH-2:0], 1'b0};
		end
	end

	assign stat.busy = (state_q != MUL_IDLE);
	assign stat.done = (state_q == MUL_DONE);
	assign remainder = rem_q;

	a_rem_lt_m: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MUL_DONE |-> rem_q < m_q) else $error("reduce result not below modulus");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MUL_DONE |=> state_q == MUL_IDLE) else $error("reduce done held");
	a_cnt_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MUL_RUN |-> cnt_q != '0) else $error("reduce counter ran out");
endmodule
`default_nettype wire
